@@ hdl/tcgd_pkg.sv @@
// shared types, constants and codes of the touch cluster gesture detector
// no dependencies
package tcgd_pkg;

    localparam int MAX_TOUCHES  = 16;
    localparam int MAX_CLUSTERS = 8;
    localparam int TCH_W        = $clog2(MAX_TOUCHES);
    localparam int CL_W         = $clog2(MAX_CLUSTERS);
    localparam int CNT_W        = 5;

    localparam logic [CNT_W-1:0] COUNT_CAP = 5'd31;

    localparam logic [1:0] MODE_PRESS   = 2'd0;
    localparam logic [1:0] MODE_MOVE    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    localparam logic [2:0] KIND_CREATED   = 3'd0;
    localparam logic [2:0] KIND_UPDATED   = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_ARM_SET   = 3'd3;
    localparam logic [2:0] KIND_ARM_CLEAR = 3'd4;
    localparam logic [2:0] KIND_TRIGGERED = 3'd5;
    localparam logic [2:0] KIND_DROPPED   = 3'd6;

    localparam logic [1:0] CFG_MIN_COUNT  = 2'd0;
    localparam logic [1:0] CFG_BOX_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_JOIN_DIST  = 2'd2;
    localparam logic [1:0] CFG_HOLD_TIME  = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         finger_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        now_ms;
    } in_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [31:0]        cluster_id;
        logic [CNT_W-1:0]   member_count;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic               last;
    } out_t;

    typedef struct packed {
        logic               valid;
        logic               armed;
        logic [CNT_W-1:0]   count;
        logic [31:0]        ident;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [31:0]        start;
    } clus_t;

    typedef struct packed {
        logic               valid;
        logic [7:0]         finger;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [CL_W-1:0]    slot;
    } tch_t;

    typedef struct packed {
        logic            we;
        logic [CL_W-1:0] sel;
        clus_t           rec;
        logic            shift;
        logic [CL_W-1:0] rm;
    } clus_ctl_t;

    typedef struct packed {
        logic             we;
        logic [TCH_W-1:0] sel;
        tch_t             rec;
        logic             dec;
        logic [CL_W-1:0]  rm;
    } tch_ctl_t;

endpackage

@@ hdl/tcgd_cluster_cell.sv @@
// one cluster slot: holds a cluster record, loads it or takes its younger neighbor's
// depends on tcgd_pkg
module tcgd_cluster_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tcgd_pkg::CL_W-1:0]   cell_index,
    input  tcgd_pkg::clus_ctl_t         ctl,
    input  tcgd_pkg::clus_t             from_next,
    output tcgd_pkg::clus_t             rec
);
    import tcgd_pkg::*;

    clus_t rec_reg;
    clus_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.shift && cell_index >= ctl.rm)
        begin
            rec_next = from_next;
        end
        else if (ctl.we && ctl.sel == cell_index)
        begin
            rec_next = ctl.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

@@ hdl/tcgd_touch_cell.sv @@
// one touch slot: finger, position and owning cluster slot
// depends on tcgd_pkg
module tcgd_touch_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tcgd_pkg::TCH_W-1:0]  cell_index,
    input  tcgd_pkg::tch_ctl_t          ctl,
    output tcgd_pkg::tch_t              rec
);
    import tcgd_pkg::*;

    tch_t rec_reg;
    tch_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.we && ctl.sel == cell_index)
        begin
            rec_next = ctl.rec;
        end
        else if (ctl.dec && rec_reg.valid && rec_reg.slot > ctl.rm)
        begin
            rec_next.slot = rec_reg.slot - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

@@ hdl/touch_cluster_gesture_detector.sv @@
// top level: sequencer, join-distance scan, touch and cluster cell rows, result output
// depends on tcgd_pkg, tcgd_touch_cell, tcgd_cluster_cell

// A press first runs the distance scan, which walks the touch cells one
// per cycle through a three-stage subtract/square/compare pipe. The EXEC
// state then updates the tables, and the EMIT state loads the output
// register. A press of a known finger scans the same way but gives no
// word. Moves and releases skip the scan: a table update and an output
// load. Each further result word enters the output register in turn,
// held while the output stalls. A press gives at most one word, a move at
// most two, and a release at most three. A new input word is taken once the last
// result word of the previous one has entered the output register.
module touch_cluster_gesture_detector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcgd_pkg::in_t       in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output tcgd_pkg::out_t      out_word,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import tcgd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;
    localparam logic [TCH_W:0] SCAN_LAST = (TCH_W+1)'(MAX_TOUCHES + 1);

    logic [1:0]        state_reg, state_next;
    in_t               in_reg;
    logic [TCH_W:0]    scan_idx_reg;
    logic              s1_v_reg;
    logic [CL_W-1:0]   s1_slot_reg;
    logic signed [16:0] s1_dx_reg, s1_dy_reg;
    logic              s2_v_reg;
    logic [CL_W-1:0]   s2_slot_reg;
    logic [31:0]       s2_dx2_reg, s2_dy2_reg;
    logic              best_found_reg;
    logic [CL_W-1:0]   best_reg;
    logic [1:0]        res_n_reg;
    logic [2:0]        kinds_reg [3];
    out_t              pay_reg;
    logic [1:0]        emit_idx_reg;
    logic              out_valid_reg;
    out_t              out_word_reg;
    logic [31:0]       next_id_reg;
    logic [CNT_W-1:0]  min_count_reg;
    logic [15:0]       box_limit_reg;
    logic [15:0]       join_dist_reg;
    logic [15:0]       hold_time_reg;
    logic [31:0]       lim_reg;

    clus_t     cl_rec [MAX_CLUSTERS];
    tch_t      tc_rec [MAX_TOUCHES];
    clus_ctl_t cl_ctl;
    tch_ctl_t  tc_ctl;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CLUSTERS; gi++)
        begin : g_cl
            clus_t nb;
            if (gi == MAX_CLUSTERS - 1)
            begin : g_end
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = cl_rec[gi+1];
            end
            tcgd_cluster_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (CL_W'(gi)),
                .ctl        (cl_ctl),
                .from_next  (nb),
                .rec        (cl_rec[gi])
            );
        end
        for (gi = 0; gi < MAX_TOUCHES; gi++)
        begin : g_tc
            tcgd_touch_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (TCH_W'(gi)),
                .ctl        (tc_ctl),
                .rec        (tc_rec[gi])
            );
        end
    endgenerate

    // lookups over the cell rows
    logic             t_found, ft_found, fc_found;
    logic [TCH_W-1:0] t_idx, ft_idx;
    logic [CL_W-1:0]  fc_idx;

    always_comb
    begin
        t_found  = 1'b0;
        ft_found = 1'b0;
        fc_found = 1'b0;
        t_idx    = '0;
        ft_idx   = '0;
        fc_idx   = '0;
        for (int i = MAX_TOUCHES - 1; i >= 0; i--)
        begin
            if (tc_rec[i].valid && tc_rec[i].finger == in_reg.finger_id)
            begin
                t_found = 1'b1;
                t_idx   = TCH_W'(i);
            end
            if (!tc_rec[i].valid)
            begin
                ft_found = 1'b1;
                ft_idx   = TCH_W'(i);
            end
        end
        for (int i = MAX_CLUSTERS - 1; i >= 0; i--)
        begin
            if (!cl_rec[i].valid)
            begin
                fc_found = 1'b1;
                fc_idx   = CL_W'(i);
            end
        end
    end

    // table update for one word
    clus_t            cr, nr;
    tch_t             tr;
    logic [CL_W-1:0]  c;
    logic signed [16:0] w, h, lim17;
    logic [31:0]      elapsed;
    logic [1:0]       n_c;
    logic [2:0]       k_c [3];
    out_t             pay_c;
    logic [31:0]      nid_c;
    logic             exec;

    always_comb
    begin
        exec   = (state_reg == ST_EXEC);
        cl_ctl = '0;
        tc_ctl = '0;
        n_c    = 2'd0;
        k_c[0] = KIND_UPDATED;
        k_c[1] = KIND_UPDATED;
        k_c[2] = KIND_UPDATED;
        nid_c  = next_id_reg;
        c      = tc_rec[t_idx].slot;
        if (in_reg.mode == MODE_PRESS)
        begin
            c = best_found_reg ? best_reg : fc_idx;
        end
        cr = cl_rec[c];
        nr = cr;
        tr = tc_rec[t_idx];
        lim17   = {1'b0, box_limit_reg};
        elapsed = in_reg.now_ms - cr.start;
        if ($signed(in_reg.pos_x) < $signed(cr.left))   nr.left   = in_reg.pos_x;
        if ($signed(in_reg.pos_x) > $signed(cr.right))  nr.right  = in_reg.pos_x;
        if ($signed(in_reg.pos_y) < $signed(cr.top))    nr.top    = in_reg.pos_y;
        if ($signed(in_reg.pos_y) > $signed(cr.bottom)) nr.bottom = in_reg.pos_y;
        w = {nr.right[15], nr.right} - {nr.left[15], nr.left};
        h = {nr.bottom[15], nr.bottom} - {nr.top[15], nr.top};

        tc_ctl.rm = c;
        cl_ctl.rm = c;

        case (in_reg.mode)
            MODE_PRESS:
            begin
                if (t_found)
                begin
                    tc_ctl.we  = 1'b1;
                    tc_ctl.sel = t_idx;
                    tr.x       = in_reg.pos_x;
                    tr.y       = in_reg.pos_y;
                end
                else if (!best_found_reg)
                begin
                    n_c = 2'd1;
                    if (!ft_found || !fc_found)
                    begin
                        k_c[0] = KIND_DROPPED;
                    end
                    else
                    begin
                        k_c[0]    = KIND_CREATED;
                        nr.valid  = 1'b1;
                        nr.armed  = 1'b0;
                        nr.count  = CNT_W'(1);
                        nr.ident  = next_id_reg;
                        nr.left   = in_reg.pos_x;
                        nr.right  = in_reg.pos_x;
                        nr.top    = in_reg.pos_y;
                        nr.bottom = in_reg.pos_y;
                        nr.start  = in_reg.now_ms;
                        nid_c     = (next_id_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                   : next_id_reg + 32'd1;
                        cl_ctl.we  = 1'b1;
                        cl_ctl.sel = c;
                        tc_ctl.we  = 1'b1;
                        tc_ctl.sel = ft_idx;
                        tr = '{valid: 1'b1, finger: in_reg.finger_id, x: in_reg.pos_x,
                               y: in_reg.pos_y, slot: c};
                    end
                end
                else
                begin
                    n_c = 2'd1;
                    if (!ft_found || cr.count >= COUNT_CAP)
                    begin
                        k_c[0] = KIND_DROPPED;
                    end
                    else
                    begin
                        k_c[0]   = KIND_UPDATED;
                        nr.count = cr.count + 1'b1;
                        if (nr.count <= min_count_reg && !cr.armed)
                        begin
                            nr.start = in_reg.now_ms;
                        end
                        cl_ctl.we  = 1'b1;
                        cl_ctl.sel = c;
                        tc_ctl.we  = 1'b1;
                        tc_ctl.sel = ft_idx;
                        tr = '{valid: 1'b1, finger: in_reg.finger_id, x: in_reg.pos_x,
                               y: in_reg.pos_y, slot: c};
                    end
                end
            end
            MODE_MOVE:
            begin
                if (t_found)
                begin
                    n_c    = 2'd1;
                    k_c[0] = KIND_UPDATED;
                    tr.x   = in_reg.pos_x;
                    tr.y   = in_reg.pos_y;
                    tc_ctl.we  = 1'b1;
                    tc_ctl.sel = t_idx;
                    cl_ctl.we  = 1'b1;
                    cl_ctl.sel = c;
                    if (cr.armed)
                    begin
                        if (w > lim17 || h > lim17)
                        begin
                            nr.armed = 1'b0;
                            n_c      = 2'd2;
                            k_c[1]   = KIND_ARM_CLEAR;
                        end
                    end
                    else if (w < lim17 && h < lim17 && cr.count >= min_count_reg &&
                             elapsed > {16'd0, hold_time_reg})
                    begin
                        nr.armed = 1'b1;
                        n_c      = 2'd2;
                        k_c[1]   = KIND_ARM_SET;
                    end
                end
            end
            MODE_RELEASE:
            begin
                nr = cr;
                if (t_found)
                begin
                    tr.valid   = 1'b0;
                    tc_ctl.we  = 1'b1;
                    tc_ctl.sel = t_idx;
                    if (cr.count != '0)
                    begin
                        nr.count = cr.count - 1'b1;
                    end
                    if (nr.count < min_count_reg && !cr.armed)
                    begin
                        nr.start = in_reg.now_ms;
                    end
                    if (nr.count == '0)
                    begin
                        cl_ctl.shift = 1'b1;
                        tc_ctl.dec   = 1'b1;
                        if (cr.armed)
                        begin
                            n_c    = 2'd3;
                            k_c[0] = KIND_TRIGGERED;
                            k_c[1] = KIND_ARM_CLEAR;
                            k_c[2] = KIND_REMOVED;
                        end
                        else
                        begin
                            n_c    = 2'd1;
                            k_c[0] = KIND_REMOVED;
                        end
                    end
                    else
                    begin
                        cl_ctl.we  = 1'b1;
                        cl_ctl.sel = c;
                    end
                end
            end
            default:
            begin
                n_c = 2'd0;
            end
        endcase

        cl_ctl.rec = nr;
        tc_ctl.rec = tr;
        pay_c = '{event_kind: KIND_UPDATED, cluster_id: nr.ident, member_count: nr.count,
                  box_left: nr.left, box_top: nr.top, box_right: nr.right,
                  box_bottom: nr.bottom, last: 1'b0};
        if (k_c[0] == KIND_DROPPED)
        begin
            pay_c = '0;
        end
        cl_ctl.we    = cl_ctl.we & exec;
        cl_ctl.shift = cl_ctl.shift & exec;
        tc_ctl.we    = tc_ctl.we & exec;
        tc_ctl.dec   = tc_ctl.dec & exec;
    end

    // distance scan pipe
    tch_t        scan_rec;
    logic [32:0] dist_sum;
    logic        near;
    logic signed [33:0] dx2_full, dy2_full;

    always_comb
    begin
        scan_rec = tc_rec[scan_idx_reg[TCH_W-1:0]];
        dx2_full = 34'(s1_dx_reg) * 34'(s1_dx_reg);
        dy2_full = 34'(s1_dy_reg) * 34'(s1_dy_reg);
        dist_sum = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
        near     = s2_v_reg && (dist_sum < {1'b0, lim_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_word.mode == MODE_PRESS) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == SCAN_LAST)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (n_c == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if ((!out_valid_reg || !out_stall) && emit_idx_reg == res_n_reg - 2'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic emit_load;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            next_id_reg    <= 32'd1;
            min_count_reg  <= 5'd5;
            box_limit_reg  <= 16'd200;
            join_dist_reg  <= 16'd300;
            hold_time_reg  <= 16'd1000;
            best_found_reg <= 1'b0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            res_n_reg      <= 2'd0;
            emit_idx_reg   <= 2'd0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_COUNT: min_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_BOX_LIMIT: box_limit_reg <= cfg_data;
                    CFG_JOIN_DIST: join_dist_reg <= cfg_data;
                    CFG_HOLD_TIME: hold_time_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && in_valid)
            begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
                s1_v_reg       <= 1'b0;
                s2_v_reg       <= 1'b0;
            end
            if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                s1_v_reg     <= (scan_idx_reg < (TCH_W+1)'(MAX_TOUCHES)) && scan_rec.valid;
                s2_v_reg     <= s1_v_reg;
                if (near && (!best_found_reg || s2_slot_reg < best_reg))
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (exec)
            begin
                next_id_reg  <= nid_c;
                res_n_reg    <= n_c;
                emit_idx_reg <= 2'd0;
            end
            if (emit_load)
            begin
                emit_idx_reg <= emit_idx_reg + 2'd1;
            end
            out_valid_reg <= emit_load | (out_valid_reg & out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= 32'(join_dist_reg) * 32'(join_dist_reg);
        if (state_reg == ST_IDLE && in_valid)
        begin
            in_reg <= in_word;
        end
        if (state_reg == ST_SCAN)
        begin
            s1_slot_reg <= scan_rec.slot;
            s1_dx_reg   <= {scan_rec.x[15], scan_rec.x} - {in_reg.pos_x[15], in_reg.pos_x};
            s1_dy_reg   <= {scan_rec.y[15], scan_rec.y} - {in_reg.pos_y[15], in_reg.pos_y};
            s2_slot_reg <= s1_slot_reg;
            s2_dx2_reg  <= dx2_full[31:0];
            s2_dy2_reg  <= dy2_full[31:0];
            if (near && (!best_found_reg || s2_slot_reg < best_reg))
            begin
                best_reg <= s2_slot_reg;
            end
        end
        if (exec)
        begin
            kinds_reg[0] <= k_c[0];
            kinds_reg[1] <= k_c[1];
            kinds_reg[2] <= k_c[2];
            pay_reg      <= pay_c;
        end
        if (emit_load)
        begin
            out_word_reg            <= pay_reg;
            out_word_reg.event_kind <= kinds_reg[emit_idx_reg];
            out_word_reg.last       <= (emit_idx_reg == res_n_reg - 2'd1);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    logic [MAX_CLUSTERS-1:0] cl_valid_vec;
    logic                    orphan;

    always_comb
    begin
        orphan = 1'b0;
        for (int i = 0; i < MAX_CLUSTERS; i++)
        begin
            cl_valid_vec[i] = cl_rec[i].valid;
        end
        for (int i = 0; i < MAX_TOUCHES; i++)
        begin
            if (tc_rec[i].valid && !cl_rec[tc_rec[i].slot].valid)
            begin
                orphan = 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_clusters_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (cl_valid_vec & (cl_valid_vec + 1'b1)) == '0)
        else $error("cluster slots not packed from slot zero");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        !orphan)
        else $error("live touch points at a free cluster slot");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (res_n_reg != 2'd0))
        else $error("emitting with no results");
`endif

endmodule
